>>> rtl/tgd_pkg.sv
// Shared constants, codes and controller/datapath command and status types
// for the group deframer. No dependencies.

package tgd_pkg;

    localparam int GROUP_BYTES = 32;
    localparam int FILL_W      = $clog2(GROUP_BYTES);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int ERR_W       = 16;
    localparam int CK_BITS     = 6;

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(GROUP_BYTES - 1);

    localparam logic [7:0] CK_OFFSET = 8'h20;

    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = CFG_IDX_W'(1);

    localparam logic [7:0] START_CHAR_RST = 8'd10;
    localparam logic [7:0] END_CHAR_RST   = 8'd13;

    localparam logic [1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic grp_clr;      // start of a new group
        logic store;        // store the accepted byte
        logic rd_start;     // rewind the read pointer
        logic rd_en;        // read the buffer at the read pointer
        logic ld_byte;      // load a payload result
        logic ld_empty;     // load an empty-group result
        logic ld_mismatch;  // load a mismatch result and count it
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic is_end;
        logic full;
        logic short_grp;
        logic two_bytes;
        logic ck_ok;
        logic rd_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/tgd_if.sv
// Stream interfaces for the input byte channel and the result channel.
// Depends on nothing; widths follow the result field definitions.

interface tgd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tgd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic        last;
    logic [15:0] error_count;

    modport source (output valid, output payload_byte, output status,
                    output last, output error_count, input ready);
    modport sink   (input valid, input payload_byte, input status,
                    input last, input error_count, output ready);
endinterface

>>> rtl/tgd_ctrl.sv
// Controller state machine of the group deframer.
// Depends on tgd_pkg for the command and status structs.

module tgd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tgd_pkg::t_dp_sts i_sts,
    output tgd_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_WAIT = 5'b00001,
        S_RECV = 5'b00010,
        S_EVAL = 5'b00100,
        S_RD   = 5'b01000,
        S_LD   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_ready = (r_state == S_WAIT) || (r_state == S_RECV);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_WAIT: begin
                if (w_acc && i_sts.is_start) begin
                    o_cmd.grp_clr = 1'b1;
                    n_state       = S_RECV;
                end
            end
            S_RECV: begin
                if (w_acc) begin
                    if (i_sts.is_end) begin
                        n_state = S_EVAL;
                    end else if (i_sts.full) begin
                        n_state = S_WAIT;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end
            end
            S_EVAL: begin
                // Short groups vanish; status-only results wait for a free slot.
                if (i_sts.short_grp) begin
                    n_state = S_WAIT;
                end else if (!i_sts.ck_ok) begin
                    if (i_sts.out_free) begin
                        o_cmd.ld_mismatch = 1'b1;
                        n_state           = S_WAIT;
                    end
                end else if (i_sts.two_bytes) begin
                    if (i_sts.out_free) begin
                        o_cmd.ld_empty = 1'b1;
                        n_state        = S_WAIT;
                    end
                end else begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LD;
            end
            S_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_byte = 1'b1;
                    n_state       = i_sts.rd_last ? S_WAIT : S_RD;
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/tgd_dp.sv
// Datapath of the group deframer: configuration registers, group buffer,
// running checksum, read pointer, mismatch counter and result register.
// Depends on tgd_pkg.

module tgd_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tgd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tgd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [7:0]                         i_rx_byte,
    input  tgd_pkg::t_dp_cmd                   i_cmd,
    output tgd_pkg::t_dp_sts                   o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [7:0]                         o_payload_byte,
    output logic [1:0]                         o_status,
    output logic                               o_last,
    output logic [tgd_pkg::ERR_W-1:0]          o_error_count
);

    logic [7:0]                    r_start_char;
    logic [7:0]                    r_end_char;
    logic [tgd_pkg::FILL_W-1:0]    r_fill;
    logic [tgd_pkg::FILL_W-1:0]    r_rd_idx;
    logic [7:0]                    r_b0;
    logic [7:0]                    r_b1;
    logic [tgd_pkg::CK_BITS-1:0]   r_sum;
    logic [7:0]                    r_mem [tgd_pkg::GROUP_BYTES];
    logic [7:0]                    r_rd_data;
    logic [tgd_pkg::ERR_W-1:0]     r_err;
    logic [tgd_pkg::ERR_W-1:0]     n_err;
    logic                          r_out_valid;
    logic [7:0]                    r_out_byte;
    logic [1:0]                    r_out_status;
    logic                          r_out_last;
    logic [tgd_pkg::ERR_W-1:0]     r_out_err;
    logic [7:0]                    w_ck;
    logic                          w_load;

    // Low bits of the sum of all bytes but the final two, plus the offset.
    assign w_ck = {{(8 - tgd_pkg::CK_BITS){1'b0}}, r_sum} + tgd_pkg::CK_OFFSET;

    assign o_sts.is_start  = (i_rx_byte == r_start_char);
    assign o_sts.is_end    = (i_rx_byte == r_end_char);
    assign o_sts.full      = (r_fill == tgd_pkg::FILL_MAX);
    assign o_sts.short_grp = (r_fill < tgd_pkg::FILL_W'(2));
    assign o_sts.two_bytes = (r_fill == tgd_pkg::FILL_W'(2));
    assign o_sts.ck_ok     = (w_ck == r_b1);
    assign o_sts.rd_last   = (r_rd_idx == r_fill - tgd_pkg::FILL_W'(3));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign w_load = i_cmd.ld_byte || i_cmd.ld_empty || i_cmd.ld_mismatch;
    assign n_err  = i_cmd.ld_mismatch ? r_err + tgd_pkg::ERR_W'(1) : r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= tgd_pkg::START_CHAR_RST;
            r_end_char   <= tgd_pkg::END_CHAR_RST;
            r_fill       <= '0;
            r_err        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == tgd_pkg::REG_START_CHAR) begin
                r_start_char <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == tgd_pkg::REG_END_CHAR) begin
                r_end_char <= i_cfg_data;
            end
            if (i_cmd.grp_clr) begin
                r_fill <= '0;
            end else if (i_cmd.store) begin
                r_fill <= r_fill + tgd_pkg::FILL_W'(1);
            end
            r_err <= n_err;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Running checksum: a byte joins the sum once two newer bytes follow it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.grp_clr) begin
            r_sum <= '0;
        end else if (i_cmd.store) begin
            if (!o_sts.short_grp) begin
                r_sum <= r_sum + r_b0[tgd_pkg::CK_BITS-1:0];
            end
            r_b0 <= r_b1;
            r_b1 <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_fill] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.ld_byte) begin
            r_rd_idx <= r_rd_idx + tgd_pkg::FILL_W'(1);
        end
        if (i_cmd.ld_byte) begin
            r_out_byte   <= r_rd_data;
            r_out_status <= tgd_pkg::ST_PAYLOAD;
            r_out_last   <= o_sts.rd_last;
        end else if (i_cmd.ld_empty) begin
            r_out_byte   <= '0;
            r_out_status <= tgd_pkg::ST_EMPTY;
            r_out_last   <= 1'b1;
        end else if (i_cmd.ld_mismatch) begin
            r_out_byte   <= '0;
            r_out_status <= tgd_pkg::ST_MISMATCH;
            r_out_last   <= 1'b1;
        end
        if (w_load) begin
            r_out_err <= n_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;
    assign o_error_count  = r_out_err;

endmodule

>>> rtl/teleinfo_group_deframer.sv
// Top level of the meter group deframer: controller plus datapath.
// Depends on tgd_pkg, tgd_in_if/tgd_out_if, tgd_ctrl and tgd_dp.
//
//   channel   direction  carries
//   i_rx      in         rx_byte
//   o_res     out        payload_byte, status, last, error_count
//   i_cfg_*   in         register writes (0 start_char, 1 end_char)
//
// Each received byte is taken in one cycle while a group is awaited or read in.
// The closing byte leads into checksum evaluation, after which a good group
// streams out byte by byte: a registered buffer read, then a load into the
// result register whenever it is free. The result register holds an item
// until it is taken; the input is held off only during evaluation and emission.
// Reset is synchronous and restores the default start and end characters.

module teleinfo_group_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tgd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tgd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tgd_in_if.sink                         i_rx,
    tgd_out_if.source                      o_res
);

    tgd_pkg::t_dp_cmd w_cmd;
    tgd_pkg::t_dp_sts w_sts;

    tgd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (i_rx.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tgd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx.rx_byte),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_payload_byte (o_res.payload_byte),
        .o_status       (o_res.status),
        .o_last         (o_res.last),
        .o_error_count  (o_res.error_count)
    );

endmodule
